/* hdl/tcpik_pkg.sv */
// Shared widths, register indexes and payload types of the two-cable plotter
// inverse kinematics core. No dependencies.
package tcpik_pkg;

    // Coordinate format: signed fixed point, CW bits with FB fraction bits.
    localparam int CW   = 32;
    localparam int FB   = 16;
    localparam int UW   = CW - 1;        // unsigned configuration lengths
    localparam int DW   = CW + 1;        // offset-corrected coordinate
    localparam int D2W  = CW + 2;        // distance to the right motor
    localparam int MW   = CW + 1;        // magnitude of a coordinate difference
    localparam int SQW  = 2 * MW;        // one square
    localparam int SUMW = SQW + 1;       // sum of two squares
    localparam int RADW = SUMW + 1;      // radicand, padded to an even width
    localparam int RTW  = RADW / 2;      // root width, one bit per sqrt stage
    localparam int REMW = RTW + 2;       // partial remainder of the sqrt
    localparam int DIFW = RTW + 1;       // signed length minus rest length
    localparam int DMW  = RTW;           // magnitude of that difference
    localparam int PW   = DMW + CW;      // product with the inverse radius
    localparam int SHW  = PW - FB;       // product after the fraction shift

    // Configuration register indexes.
    localparam int IDXW = 3;
    localparam logic [IDXW-1:0] REG_TOOL_OFFSET_X     = IDXW'(0);
    localparam logic [IDXW-1:0] REG_TOOL_OFFSET_Y     = IDXW'(1);
    localparam logic [IDXW-1:0] REG_MOTOR_SPACING     = IDXW'(2);
    localparam logic [IDXW-1:0] REG_REST_LENGTH_LEFT  = IDXW'(3);
    localparam logic [IDXW-1:0] REG_REST_LENGTH_RIGHT = IDXW'(4);
    localparam logic [IDXW-1:0] REG_INV_PULLEY_RADIUS = IDXW'(5);
    localparam logic [IDXW-1:0] REG_JOINT_MODE        = IDXW'(6);

    // Reset values of the configuration registers.
    localparam logic [UW-1:0] MOTOR_SPACING_RST = UW'(1000) << FB;
    localparam logic [CW-1:0] INV_RADIUS_RST    = CW'(1) << FB;

    typedef logic signed [CW-1:0] t_coord;

    // The raw target travels beside the math for joint mode and z.
    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_side;

endpackage

/* hdl/tcpik_if.sv */
// Valid/ready stream interfaces for target words in and joint words out.
// Depends on tcpik_pkg for the coordinate type.
interface tcpik_target_if
    import tcpik_pkg::*;
;
    logic   valid;
    logic   ready;
    t_coord target_x;
    t_coord target_y;
    t_coord target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                     input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                     output ready);
endinterface

interface tcpik_joint_if
    import tcpik_pkg::*;
;
    logic   valid;
    logic   ready;
    t_coord left_angle;
    t_coord right_angle;
    t_coord z_joint;

    modport source (output valid, output left_angle, output right_angle, output z_joint,
                     input ready);
    modport sink   (input valid, input left_angle, input right_angle, input z_joint,
                     output ready);
endinterface

/* hdl/tcpik_sqrt.sv */
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on tcpik_pkg for the radicand and root widths.
module tcpik_sqrt
    import tcpik_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [RADW-1:0] i_rad,
    output logic [RTW-1:0]  o_root
);

    logic [REMW-1:0] r_rem  [1:RTW-1];
    logic [RADW-1:0] r_rad  [1:RTW-1];
    logic [RTW-1:0]  r_root [1:RTW];

    for (genvar k = 0; k < RTW; k++) begin : g_stage
        logic [REMW-1:0] w_rem_in;
        logic [RADW-1:0] w_rad_in;
        logic [RTW-1:0]  w_root_in;
        logic [REMW-1:0] w_cand;
        logic [REMW-1:0] w_trial;
        logic            w_take;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_rad_in  = i_rad;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k];
            assign w_rad_in  = r_rad[k];
            assign w_root_in = r_root[k];
        end

        // Bring down the next two radicand bits and try appending a one.
        assign w_cand  = {w_rem_in[REMW-3:0], w_rad_in[RADW-1 -: 2]};
        assign w_trial = {w_root_in, 2'b01};
        assign w_take  = (w_cand >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k+1] <= {w_root_in[RTW-2:0], w_take};
            end
        end

        if (k < RTW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_take ? (w_cand - w_trial) : w_cand;
                    r_rad[k+1] <= {w_rad_in[RADW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_root = r_root[RTW];

endmodule

/* hdl/two_cable_plotter_inverse_kinematics_core.sv */
// Inverse kinematics of a two-cable wall plotter: target position to pulley angles.
// Depends on tcpik_pkg, the stream interfaces in tcpik_if and tcpik_sqrt.
//
// Usage:
//   i_tgt carries target words (x, y, z, signed Q16.16); o_jnt carries joint
//   words (left angle, right angle, z). A word moves when valid and ready are
//   both high at a rising clock edge.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while no
//   word is in flight; index 7 is ignored.
//   A word passes 40 register stages: three for the offset, squares and sum,
//   34 square root stages (one root bit each) and three for the rest-length
//   difference, the radius multiply and the saturation into the output register.
//   Throughput is one word per cycle while not stalled; every stage holds one word.
//   When the receiver stalls with a word in the output register, the whole
//   pipeline holds and i_tgt.ready drops in the same cycle; nothing is lost
//   or repeated. Empty stages never block.
//   Synchronous active-low reset empties the pipeline, holds i_tgt.ready low
//   and loads the register defaults (spacing 1000 mm, inverse radius 1.0).
module two_cable_plotter_inverse_kinematics_core
    import tcpik_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_idx,
    input  logic [CW-1:0]   i_cfg_data,
    tcpik_target_if.sink    i_tgt,
    tcpik_joint_if.source   o_jnt
);

    // Configuration registers.
    logic [CW-1:0] r_tool_x;
    logic [CW-1:0] r_tool_y;
    logic [UW-1:0] r_spacing;
    logic [UW-1:0] r_rest_l;
    logic [UW-1:0] r_rest_r;
    logic [CW-1:0] r_inv_r;
    logic          r_joint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tool_x  <= '0;
            r_tool_y  <= '0;
            r_spacing <= MOTOR_SPACING_RST;
            r_rest_l  <= '0;
            r_rest_r  <= '0;
            r_inv_r   <= INV_RADIUS_RST;
            r_joint   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOOL_OFFSET_X:     r_tool_x  <= i_cfg_data;
                REG_TOOL_OFFSET_Y:     r_tool_y  <= i_cfg_data;
                REG_MOTOR_SPACING:     r_spacing <= i_cfg_data[UW-1:0];
                REG_REST_LENGTH_LEFT:  r_rest_l  <= i_cfg_data[UW-1:0];
                REG_REST_LENGTH_RIGHT: r_rest_r  <= i_cfg_data[UW-1:0];
                REG_INV_PULLEY_RADIUS: r_inv_r   <= i_cfg_data;
                REG_JOINT_MODE:        r_joint   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the output register is full and held.
    logic w_en;
    logic r_out_vld;

    assign w_en        = !r_out_vld || o_jnt.ready;
    assign i_tgt.ready = i_rst_n && w_en;

    // Valid bits of every stage.
    logic              r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld;
    logic              r_q_vld [1:RTW];
    t_side             r_a_side, r_b_side, r_c_side, r_d_side, r_e_side;
    t_side             r_q_side [1:RTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 1; i <= RTW; i++) begin
                r_q_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_a_vld   <= i_tgt.valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_q_vld[1] <= r_c_vld;
            for (int i = 2; i <= RTW; i++) begin
                r_q_vld[i] <= r_q_vld[i-1];
            end
            r_d_vld   <= r_q_vld[RTW];
            r_e_vld   <= r_d_vld;
            r_out_vld <= r_e_vld;
        end
    end

    // Stage A: subtract the tool offset, distance to the right motor.
    logic signed [DW-1:0]  w_px, w_py;
    logic signed [D2W-1:0] w_px2;
    logic signed [DW-1:0]  r_a_px, r_a_py;
    logic signed [D2W-1:0] r_a_px2;

    assign w_px  = DW'(i_tgt.target_x) - DW'($signed(r_tool_x));
    assign w_py  = DW'(i_tgt.target_y) - DW'($signed(r_tool_y));
    assign w_px2 = $signed({(D2W-UW)'(0), r_spacing}) - D2W'(w_px);

    // Stage B: squares of the magnitudes.
    logic [MW-1:0]  w_mx, w_my, w_mx2;
    logic [SQW-1:0] r_b_sqx, r_b_sqy, r_b_sqx2;

    assign w_mx  = r_a_px[DW-1]   ? MW'(-r_a_px)  : MW'(r_a_px);
    assign w_my  = r_a_py[DW-1]   ? MW'(-r_a_py)  : MW'(r_a_py);
    assign w_mx2 = r_a_px2[D2W-1] ? MW'(-r_a_px2) : MW'(r_a_px2);

    // Stage C: sums of squares, the radicands of both cable lengths.
    logic [SUMW-1:0] r_c_sum_l, r_c_sum_r;

    // Square root stages.
    logic [RTW-1:0] w_root_l, w_root_r;

    tcpik_sqrt u_sqrt_l (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (RADW'(r_c_sum_l)),
        .o_root (w_root_l)
    );

    tcpik_sqrt u_sqrt_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (RADW'(r_c_sum_r)),
        .o_root (w_root_r)
    );

    // Stage D: length minus rest length, split into sign and magnitude.
    logic signed [DIFW-1:0] w_dif_l, w_dif_r;
    logic [DMW-1:0]         r_d_mag_l, r_d_mag_r;
    logic                   r_d_neg_l, r_d_neg_r;

    assign w_dif_l = $signed({1'b0, w_root_l}) - $signed({(DIFW-UW)'(0), r_rest_l});
    assign w_dif_r = $signed({1'b0, w_root_r}) - $signed({(DIFW-UW)'(0), r_rest_r});

    // Stage E: scale by the inverse pulley radius.
    logic [PW-1:0] r_e_prod_l, r_e_prod_r;
    logic          r_e_neg_l, r_e_neg_r;

    // Output stage.
    t_coord r_out_left, r_out_right, r_out_z;

    function automatic t_coord f_sat(input logic [PW-1:0] prod, input logic neg);
        localparam logic [SHW-1:0] LIM = SHW'(1) << (CW - 1);
        logic [SHW-1:0] sh;
        logic [CW-1:0]  res;
        sh = prod[PW-1:FB];
        if (!neg) begin
            res = (sh >= LIM) ? CW'(LIM - SHW'(1)) : sh[CW-1:0];
        end else begin
            // The most negative value is reached exactly, so only larger saturates.
            res = (sh > LIM) ? CW'(LIM) : (CW'(0) - sh[CW-1:0]);
        end
        return $signed(res);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_px   <= w_px;
            r_a_py   <= w_py;
            r_a_px2  <= w_px2;
            r_a_side <= '{x: i_tgt.target_x, y: i_tgt.target_y, z: i_tgt.target_z};

            r_b_sqx  <= SQW'(w_mx) * SQW'(w_mx);
            r_b_sqy  <= SQW'(w_my) * SQW'(w_my);
            r_b_sqx2 <= SQW'(w_mx2) * SQW'(w_mx2);
            r_b_side <= r_a_side;

            r_c_sum_l <= SUMW'(r_b_sqx) + SUMW'(r_b_sqy);
            r_c_sum_r <= SUMW'(r_b_sqx2) + SUMW'(r_b_sqy);
            r_c_side  <= r_b_side;

            r_q_side[1] <= r_c_side;
            for (int i = 2; i <= RTW; i++) begin
                r_q_side[i] <= r_q_side[i-1];
            end

            r_d_neg_l <= w_dif_l[DIFW-1];
            r_d_neg_r <= w_dif_r[DIFW-1];
            r_d_mag_l <= w_dif_l[DIFW-1] ? DMW'(-w_dif_l) : DMW'(w_dif_l);
            r_d_mag_r <= w_dif_r[DIFW-1] ? DMW'(-w_dif_r) : DMW'(w_dif_r);
            r_d_side  <= r_q_side[RTW];

            r_e_prod_l <= PW'(r_d_mag_l) * PW'(r_inv_r);
            r_e_prod_r <= PW'(r_d_mag_r) * PW'(r_inv_r);
            r_e_neg_l  <= r_d_neg_l;
            r_e_neg_r  <= r_d_neg_r;
            r_e_side   <= r_d_side;

            if (r_joint) begin
                r_out_left  <= r_e_side.x;
                r_out_right <= r_e_side.y;
            end else begin
                r_out_left  <= f_sat(r_e_prod_l, r_e_neg_l);
                r_out_right <= f_sat(r_e_prod_r, r_e_neg_r);
            end
            r_out_z <= r_e_side.z;
        end
    end

    assign o_jnt.valid       = r_out_vld;
    assign o_jnt.left_angle  = r_out_left;
    assign o_jnt.right_angle = r_out_right;
    assign o_jnt.z_joint     = r_out_z;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the two-cable plotter inverse kinematics core.
// Depends on tcpik_pkg, the stream interfaces in tcpik_if and the core itself.
module tb;
    import tcpik_pkg::*;

    localparam logic [IDXW-1:0] REG_NONE = IDXW'(7);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 50;

    typedef struct packed {
        t_coord left;
        t_coord right;
        t_coord z;
    } t_joint_word;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [IDXW-1:0] i_cfg_idx;
    logic [CW-1:0]   i_cfg_data;

    tcpik_target_if tgt_if ();
    tcpik_joint_if  jnt_if ();

    two_cable_plotter_inverse_kinematics_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tgt      (tgt_if),
        .o_jnt      (jnt_if)
    );

    // Shadow copy of the configuration registers.
    t_coord        off_x;
    t_coord        off_y;
    logic [UW-1:0] spacing;
    logic [UW-1:0] rest_left;
    logic [UW-1:0] rest_right;
    logic [CW-1:0] inv_radius;
    logic          joint_on;

    t_joint_word joint_words_due[$];
    int          target_words_sent;
    int          joint_words_checked;
    int          fault_count;
    int          config_phases;
    int          quiet_cycles;
    bit          idle_on;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [39:0] floor_sqrt(input logic [79:0] n);
        logic [39:0] r;
        logic [39:0] c;
        r = '0;
        for (int b = 39; b >= 0; b--) begin
            c = r | (40'd1 << b);
            if ({40'd0, c} * {40'd0, c} <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    // One cable: length from the exact root, minus rest, scaled by 1/radius,
    // truncated toward zero and saturated to the coordinate range.
    function automatic t_coord pulley_angle(input logic signed [39:0] dx,
                                            input logic signed [39:0] dy,
                                            input logic [UW-1:0] rest);
        logic [39:0]        mx;
        logic [39:0]        my;
        logic [79:0]        sum;
        logic signed [41:0] diff;
        logic [41:0]        dmag;
        logic [79:0]        scaled;
        logic [31:0]        m;
        mx     = dx[39] ? -dx : dx;
        my     = dy[39] ? -dy : dy;
        sum    = {40'd0, mx} * {40'd0, mx} + {40'd0, my} * {40'd0, my};
        diff   = $signed({2'b00, floor_sqrt(sum)}) - $signed({11'd0, rest});
        dmag   = diff[41] ? -diff : diff;
        scaled = ({38'd0, dmag} * {48'd0, inv_radius}) >> FB;
        if (!diff[41]) begin
            if (scaled > {48'd0, 32'h7fff_ffff}) begin
                return 32'h7fff_ffff;
            end
            return scaled[31:0];
        end
        if (scaled > {48'd0, 32'h8000_0000}) begin
            return 32'h8000_0000;
        end
        m = scaled[31:0];
        return ~m + 32'd1;
    endfunction

    function automatic t_joint_word compute_joint_word(input t_coord x, input t_coord y,
                                                       input t_coord z);
        t_joint_word        w;
        logic signed [39:0] px;
        logic signed [39:0] py;
        logic signed [39:0] pxr;
        px  = x - off_x;
        py  = y - off_y;
        pxr = $signed({9'd0, spacing}) - px;
        if (joint_on) begin
            w.left  = x;
            w.right = y;
        end else begin
            w.left  = pulley_angle(px, py, rest_left);
            w.right = pulley_angle(pxr, py, rest_right);
        end
        w.z = z;
        return w;
    endfunction

    function automatic void note_fault(input string msg);
        if (fault_count < 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
        fault_count++;
    endfunction

    // Sends one target word; called and left at a falling edge. Valid stays
    // high afterwards so back-to-back words need no extra assignment.
    task automatic send_target(input t_coord x, input t_coord y, input t_coord z);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            tgt_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tgt_if.valid    <= 1'b1;
        tgt_if.target_x <= x;
        tgt_if.target_y <= y;
        tgt_if.target_z <= z;
        do begin
            @(posedge i_clk);
        end while (!tgt_if.ready);
        joint_words_due.push_back(compute_joint_word(x, y, z));
        target_words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        tgt_if.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (joint_words_due.size() != 0);
    endtask

    task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_TOOL_OFFSET_X:     off_x      = data;
            REG_TOOL_OFFSET_Y:     off_y      = data;
            REG_MOTOR_SPACING:     spacing    = data[UW-1:0];
            REG_REST_LENGTH_LEFT:  rest_left  = data[UW-1:0];
            REG_REST_LENGTH_RIGHT: rest_right = data[UW-1:0];
            REG_INV_PULLEY_RADIUS: inv_radius = data;
            REG_JOINT_MODE:        joint_on   = data[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                              input logic [CW-1:0] sp, input logic [CW-1:0] rl,
                              input logic [CW-1:0] rr, input logic [CW-1:0] ip,
                              input bit jm);
        wait_drained();
        write_reg(REG_TOOL_OFFSET_X, ox);
        write_reg(REG_TOOL_OFFSET_Y, oy);
        write_reg(REG_MOTOR_SPACING, sp);
        write_reg(REG_REST_LENGTH_LEFT, rl);
        write_reg(REG_REST_LENGTH_RIGHT, rr);
        write_reg(REG_INV_PULLEY_RADIUS, ip);
        // Upper bits of the mode word are junk on purpose; only bit 0 counts.
        write_reg(REG_JOINT_MODE, ($urandom() & ~32'd1) | CW'(jm));
        config_phases++;
    endtask

    // Plotter-sized coordinates most of the time, any 32-bit value otherwise.
    function automatic t_coord pick_coord();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom();
        end
        return $urandom_range(0, 393216000) - 32'd196608000;
    endfunction

    function automatic logic [CW-1:0] pick_offset();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom();
            default: return $urandom_range(0, 6553600) - 32'd3276800;
        endcase
    endfunction

    function automatic logic [CW-1:0] pick_rest();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return 32'h7fff_ffff;
            2: return $urandom();
            default: return $urandom_range(0, 262144000);
        endcase
    endfunction

    task automatic program_random_setup(input bit jm);
        logic [CW-1:0] sp;
        logic [CW-1:0] ip;
        case ($urandom_range(0, 7))
            0: sp = '0;
            1: sp = 32'hffff_ffff;
            2: sp = $urandom();
            default: sp = $urandom_range(6553600, 262144000);
        endcase
        case ($urandom_range(0, 8))
            0: ip = '0;
            1: ip = 32'hffff_ffff;
            2: ip = 32'd1;
            3: ip = $urandom();
            default: ip = $urandom_range(655, 655360);
        endcase
        set_config(pick_offset(), pick_offset(), sp, pick_rest(), pick_rest(), ip, jm);
        if ($urandom_range(0, 2) == 0) begin
            write_reg(REG_NONE, $urandom());
        end
    endtask

    task automatic test_reset_defaults();
        send_target(0, 0, 0);
        send_target(32'd32768000, 32'd19660800, 32'd7);
        send_target(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_target(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_target(32'h8000_0000, 32'h7fff_ffff, 32'h5555_aaaa);
        send_target(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    endtask

    task automatic test_extreme_config();
        // Largest offsets, spacing, rest lengths and radius: saturation both ways.
        set_config(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'hffff_ffff, 1'b0);
        send_target(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
        send_target(32'h7fff_ffff, 32'h8000_0000, 32'haaaa_5555);
        send_target(0, 0, 0);
        set_config(0, 0, 0, 0, 0, 32'd1, 1'b0);
        send_target(32'h7fff_ffff, 32'h7fff_ffff, 32'd3);
        send_target(32'hffff_ffff, 32'hffff_ffff, 32'd4);
        // Zero inverse radius gives zero angles.
        set_config(0, 0, MOTOR_SPACING_RST, 0, 0, 0, 1'b0);
        send_target(32'h8000_0000, 32'h8000_0000, 32'd5);
        send_target(32'd123, 32'd456, 32'd6);
        // Rest lengths far beyond the cable length give negative angles.
        set_config(0, 0, MOTOR_SPACING_RST, 32'h7fff_ffff, 32'h7fff_ffff,
                   INV_RADIUS_RST, 1'b0);
        send_target(0, 0, 32'd8);
    endtask

    task automatic test_joint_mode_directed();
        set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), 1'b1);
        send_target(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
        send_target(32'h8000_0000, 32'h7fff_ffff, 32'h8765_4321);
        // A write to the unused index must leave every register alone.
        wait_drained();
        write_reg(REG_NONE, 32'h0000_0000);
        send_target(32'd5, 32'd6, 32'd7);
    endtask

    task automatic test_random_kinematics();
        for (int p = 0; p < 12; p++) begin
            program_random_setup(1'b0);
            repeat (60) send_target(pick_coord(), pick_coord(), $urandom());
        end
    endtask

    task automatic test_random_joint_mode();
        for (int p = 0; p < 2; p++) begin
            program_random_setup(1'b1);
            repeat (50) send_target($urandom(), $urandom(), $urandom());
        end
    endtask

    task automatic test_steady_stream();
        set_config(pick_offset(), pick_offset(), MOTOR_SPACING_RST,
                   $urandom_range(0, 65536000), $urandom_range(0, 65536000),
                   INV_RADIUS_RST, 1'b0);
        idle_on = 1'b0;
        repeat (230) send_target(pick_coord(), pick_coord(), $urandom());
    endtask

    // Receiver: ready drops at random while idling is on and stays high otherwise.
    int ready_hold;
    always @(negedge i_clk) begin
        if (!idle_on) begin
            jnt_if.ready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (jnt_if.ready && $urandom_range(0, 5) == 0) begin
            jnt_if.ready <= 1'b0;
            ready_hold = $urandom_range(0, 14);
        end else begin
            jnt_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_joint_words
        t_joint_word got;
        t_joint_word want;
        if (i_rst_n && jnt_if.valid && jnt_if.ready) begin
            got.left  = jnt_if.left_angle;
            got.right = jnt_if.right_angle;
            got.z     = jnt_if.z_joint;
            if (joint_words_due.size() == 0) begin
                note_fault($sformatf("joint word with none pending: L=%0d R=%0d Z=%0d",
                                     got.left, got.right, got.z));
            end else begin
                want = joint_words_due.pop_front();
                if (got.left !== want.left || got.right !== want.right
                        || got.z !== want.z) begin
                    note_fault($sformatf(
                        "joint word mismatch: expected L=%0d R=%0d Z=%0d, got L=%0d R=%0d Z=%0d",
                        want.left, want.right, want.z, got.left, got.right, got.z));
                end
                joint_words_checked++;
            end
        end
    end

    // Watchdog: too many cycles in a row with no word moving on either side.
    always @(posedge i_clk) begin
        if ((tgt_if.valid && tgt_if.ready) || (jnt_if.valid && jnt_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        tgt_if.valid    = 1'b0;
        tgt_if.target_x = '0;
        tgt_if.target_y = '0;
        tgt_if.target_z = '0;
        jnt_if.ready    = 1'b1;
        ready_hold      = 0;
        quiet_cycles    = 0;
        idle_on         = 1'b1;
        off_x           = '0;
        off_y           = '0;
        spacing         = MOTOR_SPACING_RST;
        rest_left       = '0;
        rest_right      = '0;
        inv_radius      = INV_RADIUS_RST;
        joint_on        = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_extreme_config();
        test_joint_mode_directed();
        test_random_kinematics();
        test_random_joint_mode();
        test_steady_stream();

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d target words over %0d register setups; checked %0d joint words.",
                 target_words_sent, config_phases, joint_words_checked);
        $display("Covered reset defaults, extreme and zero radius, joint mode, %0d faults.",
                 fault_count);
        if (fault_count == 0 && joint_words_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
